@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros used by grid_index_rotate
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted
`define GIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also covers the reset cycles
`define GIR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/gir_pkg.sv @@
// ---------------------------------------------------------------------------
// gir_pkg
// Shared widths, register codes and types of the grid index rotator.
// ---------------------------------------------------------------------------
package gir_pkg;

  localparam int MAX_SIZE_DEF = 1024;

  localparam int IDX_W      = 30;
  localparam int ROT_W      = 4;
  localparam int CFG_SIZE_W = 11;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // d = 2a + s, one sign bit on top
  localparam int D_W    = IDX_W + 2;
  localparam int PROD_W = ROT_W + D_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int MAG_W  = ACC_W - 1;

  localparam int MAT_N = 9;
  localparam int MAT_W = MAT_N * ROT_W;

  typedef logic [MAT_N-1:0][ROT_W-1:0] rot_mat_t;
  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_SIZE_X = 3'd0;
  localparam reg_idx_t REG_SIZE_Y = 3'd1;
  localparam reg_idx_t REG_SIZE_Z = 3'd2;
  localparam reg_idx_t REG_SHIFT_X = 3'd3;
  localparam reg_idx_t REG_SHIFT_Y = 3'd4;
  localparam reg_idx_t REG_SHIFT_Z = 3'd5;
  localparam reg_idx_t REG_ORDER = 3'd6;

endpackage

@@ rtl/gir_div.sv @@
// ---------------------------------------------------------------------------
// gir_div
// Pipelined restoring divider, one quotient bit per register stage, with a
// side-band word that travels along with each item.
// ---------------------------------------------------------------------------
module gir_div #(
  parameter int NUM_W  = 30,
  parameter int DEN_W  = 11,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quo,
  output logic [DEN_W-1:0]  out_rem,
  output logic [DEN_W-1:0]  out_den,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld_r  [NUM_W];
  logic [NUM_W-1:0]  wk_r   [NUM_W];
  logic [DEN_W-1:0]  rem_r  [NUM_W];
  logic [DEN_W-1:0]  den_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];

  for (genvar g = 0; g < NUM_W; g++) begin : g_stage
    logic              pv;
    logic [NUM_W-1:0]  pwk;
    logic [DEN_W-1:0]  prem;
    logic [DEN_W-1:0]  pden;
    logic [SIDE_W-1:0] pside;
    logic [DEN_W:0]    trial;
    logic              ge;

    if (g == 0) begin : g_first
      assign pv    = in_valid;
      assign pwk   = in_num;
      assign prem  = '0;
      assign pden  = in_den;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = vld_r[g-1];
      assign pwk   = wk_r[g-1];
      assign prem  = rem_r[g-1];
      assign pden  = den_r[g-1];
      assign pside = side_r[g-1];
    end

    // bring down the next numerator bit and try the subtract
    assign trial = {prem, pwk[NUM_W-1]};
    assign ge    = (trial >= {1'b0, pden});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        wk_r[g]   <= {pwk[NUM_W-2:0], ge};
        rem_r[g]  <= ge ? DEN_W'(trial - {1'b0, pden}) : trial[DEN_W-1:0];
        den_r[g]  <= pden;
        side_r[g] <= pside;
      end
    end
  end

  assign out_valid = vld_r[NUM_W-1];
  assign out_quo   = wk_r[NUM_W-1];
  assign out_rem   = rem_r[NUM_W-1];
  assign out_den   = den_r[NUM_W-1];
  assign out_side  = side_r[NUM_W-1];

endmodule

@@ rtl/gir_rot.sv @@
// ---------------------------------------------------------------------------
// gir_rot
// Rotation of the doubled, shifted coordinates: products, row sums with
// halving toward zero, then sign and magnitude for the modulo lanes.
// ---------------------------------------------------------------------------
module gir_rot import gir_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2:0][IDX_W-1:0] in_coord,
  input  logic [2:0]            in_shift,
  input  rot_mat_t              in_mat,
  output logic                  out_valid,
  output logic [2:0][MAG_W-1:0] out_mag,
  output logic [2:0]            out_neg
);

  logic signed [D_W-1:0]    d      [3];
  logic signed [PROD_W-1:0] prod   [3][3];
  logic signed [PROD_W-1:0] prod_r [3][3];
  logic signed [MAG_W-1:0]  t_nxt  [3];
  logic signed [MAG_W-1:0]  t_r    [3];
  logic [2:0][MAG_W-1:0]    mag_r;
  logic [2:0]               neg_r;
  logic [2:0]               v_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      d[j] = $signed({1'b0, in_coord[j], in_shift[j]});
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[i][j] = $signed(in_mat[i*3+j]) * d[j];
      end
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] hv;
    for (int i = 0; i < 3; i++) begin
      acc = ACC_W'(prod_r[i][0]) + ACC_W'(prod_r[i][1]) + ACC_W'(prod_r[i][2])
            - $signed({{(ACC_W-1){1'b0}}, in_shift[i]});
      // odd negative values round toward zero
      hv = acc + $signed({{(ACC_W-1){1'b0}}, acc[ACC_W-1] & acc[0]});
      t_nxt[i] = MAG_W'(hv >>> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod;
      t_r    <= t_nxt;
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= t_r[i][MAG_W-1];
        mag_r[i] <= t_r[i][MAG_W-1] ? MAG_W'(-t_r[i]) : MAG_W'(t_r[i]);
      end
    end
  end

  assign out_valid = v_r[2];
  assign out_mag   = mag_r;
  assign out_neg   = neg_r;

endmodule

@@ rtl/grid_index_rotate.sv @@
// ---------------------------------------------------------------------------
// grid_index_rotate
// Maps a linear grid point index to the index of its rotated image on a
// 3-D regular grid with per-axis half-step shifts.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   point index, 3x3 rotation
// out_      output     out_valid/out_stall rotated index
// APB       config     psel/penable/pready sizes, shifts, order
//
// One item per cycle unless the output stalls: two 30-stage dividers split
// the index, three stages rotate, 37-stage dividers reduce each axis, then
// three stages fix sign, repack and register the result.
// Synchronous active-low reset clears the valid bits; no clearing pass.
// A stalled output holds the whole pipeline in place while out_valid is high.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_index_rotate import gir_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [IDX_W-1:0]      in_point_index,
  input  logic signed [ROT_W-1:0] in_rot_00,
  input  logic signed [ROT_W-1:0] in_rot_01,
  input  logic signed [ROT_W-1:0] in_rot_02,
  input  logic signed [ROT_W-1:0] in_rot_10,
  input  logic signed [ROT_W-1:0] in_rot_11,
  input  logic signed [ROT_W-1:0] in_rot_12,
  input  logic signed [ROT_W-1:0] in_rot_20,
  input  logic signed [ROT_W-1:0] in_rot_21,
  input  logic signed [ROT_W-1:0] in_rot_22,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [IDX_W-1:0]      out_rotated_index,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SZ_W = $clog2(MAX_SIZE + 1);
  localparam int PK_W = 3 * SZ_W;

  logic [CFG_SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic                  shift_x_r, shift_y_r, shift_z_r, order_r;
  logic [SZ_W-1:0]       n_eff [3];
  reg_idx_t              reg_sel;
  logic                  en;

  // -------------------------------------------------------------------------
  // Configuration
  // -------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r  <= CFG_SIZE_W'(1);
      size_y_r  <= CFG_SIZE_W'(1);
      size_z_r  <= CFG_SIZE_W'(1);
      shift_x_r <= 1'b0;
      shift_y_r <= 1'b0;
      shift_z_r <= 1'b0;
      order_r   <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_SIZE_X:  size_x_r  <= pwdata[CFG_SIZE_W-1:0];
        REG_SIZE_Y:  size_y_r  <= pwdata[CFG_SIZE_W-1:0];
        REG_SIZE_Z:  size_z_r  <= pwdata[CFG_SIZE_W-1:0];
        REG_SHIFT_X: shift_x_r <= pwdata[0];
        REG_SHIFT_Y: shift_y_r <= pwdata[0];
        REG_SHIFT_Z: shift_z_r <= pwdata[0];
        REG_ORDER:   order_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SIZE_X:  prdata = APB_DATA_W'(size_x_r);
      REG_SIZE_Y:  prdata = APB_DATA_W'(size_y_r);
      REG_SIZE_Z:  prdata = APB_DATA_W'(size_z_r);
      REG_SHIFT_X: prdata = APB_DATA_W'(shift_x_r);
      REG_SHIFT_Y: prdata = APB_DATA_W'(shift_y_r);
      REG_SHIFT_Z: prdata = APB_DATA_W'(shift_z_r);
      REG_ORDER:   prdata = APB_DATA_W'(order_r);
      default:     prdata = '0;
    endcase
  end

  // zero acts as one, oversized clamps to the largest size
  always_comb begin
    logic [CFG_SIZE_W-1:0] raw [3];
    raw[0] = size_x_r;
    raw[1] = size_y_r;
    raw[2] = size_z_r;
    for (int i = 0; i < 3; i++) begin
      if (raw[i] == '0) begin
        n_eff[i] = SZ_W'(1);
      end else if (32'(raw[i]) > 32'(MAX_SIZE)) begin
        n_eff[i] = SZ_W'(MAX_SIZE);
      end else begin
        n_eff[i] = SZ_W'(raw[i]);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Pipeline advance: everything moves unless a finished result is held
  // -------------------------------------------------------------------------
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // -------------------------------------------------------------------------
  // Split the index: fastest axis first, then middle and slowest
  // -------------------------------------------------------------------------
  rot_mat_t                 in_mat;
  logic [SZ_W-1:0]          n_fast;
  logic                     d1_v, d2_v;
  logic [IDX_W-1:0]         d1_q, d2_q;
  logic [SZ_W-1:0]          d1_r, d2_r, d1_den, d2_den;
  logic [MAT_W-1:0]         d1_side;
  logic [MAT_W+SZ_W-1:0]    d2_side;

  assign in_mat = {in_rot_22, in_rot_21, in_rot_20, in_rot_12, in_rot_11,
                   in_rot_10, in_rot_02, in_rot_01, in_rot_00};
  assign n_fast = order_r ? n_eff[2] : n_eff[0];

  gir_div #(.NUM_W(IDX_W), .DEN_W(SZ_W), .SIDE_W(MAT_W)) u_div_fast (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_num    (in_point_index),
    .in_den    (n_fast),
    .in_side   (in_mat),
    .out_valid (d1_v),
    .out_quo   (d1_q),
    .out_rem   (d1_r),
    .out_den   (d1_den),
    .out_side  (d1_side)
  );

  gir_div #(.NUM_W(IDX_W), .DEN_W(SZ_W), .SIDE_W(MAT_W + SZ_W)) u_div_mid (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d1_v),
    .in_num    (d1_q),
    .in_den    (n_eff[1]),
    .in_side   ({d1_side, d1_r}),
    .out_valid (d2_v),
    .out_quo   (d2_q),
    .out_rem   (d2_r),
    .out_den   (d2_den),
    .out_side  (d2_side)
  );

  // -------------------------------------------------------------------------
  // Rotate
  // -------------------------------------------------------------------------
  logic [2:0][IDX_W-1:0] coord;
  logic [IDX_W-1:0]      a_fast;
  logic                  rt_v;
  logic [2:0][MAG_W-1:0] rt_mag;
  logic [2:0]            rt_neg;

  assign a_fast   = IDX_W'(d2_side[SZ_W-1:0]);
  assign coord[0] = order_r ? d2_q : a_fast;
  assign coord[1] = IDX_W'(d2_r);
  assign coord[2] = order_r ? a_fast : d2_q;

  gir_rot u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d2_v),
    .in_coord  (coord),
    .in_shift  ({shift_z_r, shift_y_r, shift_x_r}),
    .in_mat    (rot_mat_t'(d2_side[MAT_W+SZ_W-1:SZ_W])),
    .out_valid (rt_v),
    .out_mag   (rt_mag),
    .out_neg   (rt_neg)
  );

  // -------------------------------------------------------------------------
  // Reduce each axis into [0, size)
  // -------------------------------------------------------------------------
  logic [2:0]      md_v;
  logic [2:0]      md_neg;
  logic [SZ_W-1:0] md_rem [3];
  logic [SZ_W-1:0] md_den [3];
  logic            md_in_range;

  for (genvar i = 0; i < 3; i++) begin : g_mod
    gir_div #(.NUM_W(MAG_W), .DEN_W(SZ_W), .SIDE_W(1)) u_div_mod (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (rt_v),
      .in_num    (rt_mag[i]),
      .in_den    (n_eff[i]),
      .in_side   (rt_neg[i]),
      .out_valid (md_v[i]),
      .out_quo   (),
      .out_rem   (md_rem[i]),
      .out_den   (md_den[i]),
      .out_side  (md_neg[i])
    );
  end

  assign md_in_range = (md_rem[0] < md_den[0]) && (md_rem[1] < md_den[1])
                       && (md_rem[2] < md_den[2]);

  // -------------------------------------------------------------------------
  // Sign fix, repack, output register
  // -------------------------------------------------------------------------
  logic [SZ_W-1:0]   rr_r [3];
  logic              fx_v_r, pk_v_r, out_valid_r;
  logic [2*SZ_W-1:0] pk_p1_r;
  logic [SZ_W-1:0]   pk_fast_r;
  logic [SZ_W-1:0]   pk_nf_r;
  logic [IDX_W-1:0]  out_rotated_index_r;
  logic [SZ_W-1:0]   r_slow, r_fast;
  logic [PK_W-1:0]   pk_sum;

  assign r_slow = order_r ? rr_r[0] : rr_r[2];
  assign r_fast = order_r ? rr_r[2] : rr_r[0];
  assign pk_sum = PK_W'(pk_p1_r) * PK_W'(pk_nf_r) + PK_W'(pk_fast_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_v_r      <= 1'b0;
      pk_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      fx_v_r      <= md_v[0];
      pk_v_r      <= fx_v_r;
      out_valid_r <= pk_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rr_r[i] <= (md_neg[i] && (md_rem[i] != '0)) ? SZ_W'(n_eff[i] - md_rem[i])
                                                     : md_rem[i];
      end
      pk_p1_r             <= (2*SZ_W)'(r_slow) * (2*SZ_W)'(n_eff[1])
                             + (2*SZ_W)'(rr_r[1]);
      pk_fast_r           <= r_fast;
      pk_nf_r             <= n_fast;
      out_rotated_index_r <= IDX_W'(pk_sum);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_rotated_index = out_rotated_index_r;

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
  `GIR_ASSERT(a_div_fast_rem, d1_v |-> (d1_r < d1_den), "fast-axis remainder not below size")
  `GIR_ASSERT(a_div_mid_rem, d2_v |-> (d2_r < d2_den), "mid-axis remainder not below size")
  `GIR_ASSERT(a_mod_rem, md_v[0] |-> md_in_range, "axis reduction out of range")
  `GIR_ASSERT(a_mod_lanes, (md_v[0] == md_v[1]) && (md_v[0] == md_v[2]), "lanes out of step")
  `GIR_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid right after reset")

endmodule
